// ===== rtl/srlc_pkg.sv =====
// Shared types, constants and fixed-point helpers for the two-axis slew-limited controller.
// No dependencies; every rtl file imports this package.
package srlc_pkg;

    localparam int WORK_W    = 50;
    localparam int OP_W      = 33;
    localparam int PROD_W    = 66;
    localparam int MAG_W     = 48;
    localparam int DSR_W     = 24;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int RECIP_SH  = 32;

    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [OP_W-1:0]   op_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING         = 3'd4;

    typedef struct packed {
        logic [15:0] update_interval;
        logic [15:0] norm_scale;
        logic [15:0] gain;
        logic [15:0] smoothing;
        logic [15:0] damping;
    } cfg_t;

    localparam work_t ONE       = work_t'(65536);
    localparam work_t LIM3      = work_t'(196608);
    localparam work_t RATE_LIM  = work_t'(655360);
    localparam work_t SLEW_LIM  = work_t'(157286);
    localparam work_t OUT_LIM   = work_t'(25600);
    localparam work_t TEL_MAX   = work_t'(8388607);
    localparam work_t TEL_MIN   = -work_t'(8388608);
    localparam work_t MIN_DIV   = work_t'(256);
    // ceil(2^32 / 5): exact quotient by five for 0 <= x < 2^30
    localparam work_t RECIP5    = work_t'(858993460);
    localparam logic [15:0] HALF_MS = 16'd128;

    function automatic work_t clampw(input work_t v, input work_t lo, input work_t hi);
        work_t r;
        r = v;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        return r;
    endfunction

    // divide by 65536, truncating toward zero
    function automatic work_t trunc16(input prod_t p);
        prod_t t;
        t = p + ((p < 0) ? prod_t'(65535) : prod_t'(0));
        return t[PROD_W-1:16];
    endfunction

    // times 3/4, truncating toward zero
    function automatic work_t q34(input work_t v);
        work_t y;
        y = v + (v <<< 1);
        y = y + ((y < 0) ? work_t'(3) : work_t'(0));
        return y >>> 2;
    endfunction

    function automatic logic opposite(input work_t v, input work_t e);
        return ((v < 0) && (e > 0)) || ((v > 0) && (e < 0));
    endfunction

endpackage

// ===== rtl/srlc_div.sv =====
// Shared signed divider, one quotient bit per cycle, quotient truncated toward zero.
// Depends on srlc_pkg.
module srlc_div
    import srlc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  work_t            dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output work_t            quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;

    work_t            mag;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;
    logic [DSR_W-1:0] rem_step;

    always_comb
    begin
        mag      = (dividend < 0) ? -dividend : dividend;
        trial    = {rem_reg, quo_reg[MAG_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = trial >= {1'b0, dsr_reg};
        rem_step = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
                neg_reg  <= dividend < 0;
                quo_reg  <= mag[MAG_W-1:0];
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[MAG_W-2:0], ge};
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -work_t'({2'b00, quo_reg}) : work_t'({2'b00, quo_reg});

endmodule

// ===== rtl/srlc_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on srlc_pkg.
module srlc_mul
    import srlc_pkg::*;
(
    input  logic  clk,
    input  op_t   a,
    input  op_t   b,
    output prod_t p
);

    prod_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= prod_t'(a) * prod_t'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/srlc_core.sv =====
// Sequencer and controller state for both axes; drives the shared divider and multiplier.
// Depends on srlc_pkg, srlc_div and srlc_mul.
module srlc_core
    import srlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] error_x,
    input  logic signed [23:0] error_y,
    input  logic [15:0]        elapsed_ms,
    input  logic               update_state,
    input  logic               close_to_target,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] step_x,
    output logic signed [15:0] step_y,
    output logic signed [23:0] x_proportional,
    output logic signed [23:0] x_slew_residual,
    output logic signed [23:0] x_filtered_term,
    output logic signed [23:0] y_proportional,
    output logic signed [23:0] y_slew_residual,
    output logic signed [23:0] y_filtered_term
);

    typedef enum logic [5:0] {
        S_IDLE, S_AX_BEGIN, S_RATE_W, S_NE_M, S_NE_D, S_NE_W, S_NM_W, S_NR1, S_NR2,
        S_SM1, S_SM2, S_SM3, S_FA1, S_FA2, S_PR1, S_PR2, S_FRAC_W, S_ADQ1, S_ADQ2,
        S_AMT1, S_AMT2, S_BRK1, S_BRK2, S_BRK3, S_BRK4, S_OVS, S_T1, S_T2,
        S_T3, S_T4, S_ST1, S_ST2, S_NEXT, S_CLX1, S_CLX2, S_CLY1, S_CLY2, S_DONE
    } state_t;

    state_t state_reg;
    logic   ax_reg;

    logic signed [23:0] ex_reg;
    logic signed [23:0] ey_reg;
    logic [15:0]        el_reg;
    logic               upd_reg;
    logic               close_reg;

    logic signed [23:0] last_e_reg [2];
    logic signed [19:0] fa_st_reg  [2];
    logic signed [19:0] cmd_reg    [2];
    logic signed [23:0] tel_reg    [2][3];
    logic signed [15:0] step_reg   [2];

    work_t rate_reg, ne_reg, nm_reg, near_reg, avail_reg, smooth_reg;
    work_t fa_reg, req_reg, prop_reg, brake_reg, frac_reg, adq_reg, mult_reg, dif_reg;

    logic             div_start_reg;
    work_t            div_dvd_reg;
    logic [DSR_W-1:0] div_dsr_reg;
    logic             div_done;
    work_t            div_q;

    op_t   mul_a;
    op_t   mul_b;
    prod_t mul_p;

    work_t cur_e, prev, ae, pm, nz, ut, fa_cur, cmd_cur, fa_target;
    work_t fa_upd, fa_adj, req_o, fa_o, delta, applied, cmd_new, av0, av1, tp;
    work_t de, q5, st3, st3_mag, cl_q;
    logic signed [15:0] st_sel;
    logic  neg_e, ovs, brk_cond;

    srlc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dsr_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    srlc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_comb
    begin
        cur_e     = ax_reg ? work_t'(ey_reg) : work_t'(ex_reg);
        prev      = work_t'(last_e_reg[ax_reg]);
        fa_cur    = work_t'(fa_st_reg[ax_reg]);
        cmd_cur   = work_t'(cmd_reg[ax_reg]);
        neg_e     = cur_e < 0;
        ae        = neg_e ? -cur_e : cur_e;
        pm        = (prev < 0) ? -prev : prev;
        de        = cur_e - prev;
        nz        = (work_t'(cfg.norm_scale) < MIN_DIV) ? MIN_DIV : work_t'(cfg.norm_scale);
        ut        = (work_t'(cfg.update_interval) < MIN_DIV) ? MIN_DIV
                                                             : work_t'(cfg.update_interval);
        tp        = trunc16(mul_p);
        q5        = work_t'(mul_p[PROD_W-1:RECIP_SH]);
        st_sel    = ((state_reg == S_CLY1) || (state_reg == S_CLY2)) ? step_reg[1]
                                                                     : step_reg[0];
        st3       = work_t'(st_sel) + (work_t'(st_sel) <<< 1);
        st3_mag   = (st3 < 0) ? -st3 : st3;
        cl_q      = (st3 < 0) ? -q5 : q5;
        fa_target = neg_e ? -avail_reg : avail_reg;
        fa_upd    = fa_cur + tp;
        fa_adj    = opposite(fa_upd, cur_e) ? q34(fa_upd) : fa_upd;
        ovs       = opposite(req_reg, cur_e);
        req_o     = ovs ? q34(req_reg) : req_reg;
        fa_o      = ovs ? q34(fa_reg) : fa_reg;
        delta     = req_o - cmd_cur;
        applied   = clampw(delta, -SLEW_LIM, SLEW_LIM);
        cmd_new   = clampw(cmd_cur + applied, -LIM3, LIM3);
        av0       = neg_e ? rate_reg : -rate_reg;
        av1       = (av0 < 0) ? '0 : av0;
        brk_cond  = (pm > MIN_DIV) && (pm > ae)
                    && (((prev > 0) && (cur_e > 0)) || ((prev < 0) && (cur_e < 0)));
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_NE_M:
            begin
                mul_a = op_t'(cur_e);
                mul_b = op_t'(cfg.gain);
            end
            S_NR1:
            begin
                mul_a = op_t'(ae <<< 6);
                mul_b = op_t'(RECIP5);
            end
            S_SM1:
            begin
                mul_a = op_t'(nz);
                mul_b = op_t'(cfg.smoothing);
            end
            S_SM2:
            begin
                mul_a = op_t'(mul_p);
                mul_b = op_t'(near_reg);
            end
            S_FA1:
            begin
                mul_a = op_t'(fa_target - fa_cur);
                mul_b = op_t'(smooth_reg);
            end
            S_PR1:
            begin
                mul_a = op_t'(ne_reg);
                mul_b = op_t'(nz);
            end
            S_ADQ1:
            begin
                mul_a = op_t'({cfg.damping, 8'd0});
                mul_b = op_t'(RECIP5);
            end
            S_AMT1:
            begin
                mul_a = op_t'(frac_reg);
                mul_b = op_t'(adq_reg);
            end
            S_BRK1:
            begin
                mul_a = op_t'(req_reg);
                mul_b = op_t'(mult_reg);
            end
            S_BRK3, S_T1:
            begin
                mul_a = op_t'(dif_reg);
                mul_b = op_t'(nz);
            end
            S_T3:
            begin
                mul_a = op_t'(fa_cur);
                mul_b = op_t'(nz);
            end
            S_ST1:
            begin
                mul_a = op_t'(el_reg);
                mul_b = op_t'(cmd_cur);
            end
            S_CLX1, S_CLY1:
            begin
                mul_a = op_t'(st3_mag);
                mul_b = op_t'(RECIP5);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= 1'b0;
            ex_reg        <= '0;
            ey_reg        <= '0;
            el_reg        <= '0;
            upd_reg       <= 1'b0;
            close_reg     <= 1'b0;
            div_start_reg <= 1'b0;
            div_dvd_reg   <= '0;
            div_dsr_reg   <= '0;
            rate_reg      <= '0;
            ne_reg        <= '0;
            nm_reg        <= '0;
            near_reg      <= '0;
            avail_reg     <= '0;
            smooth_reg    <= '0;
            fa_reg        <= '0;
            req_reg       <= '0;
            prop_reg      <= '0;
            brake_reg     <= '0;
            frac_reg      <= '0;
            adq_reg       <= '0;
            mult_reg      <= '0;
            dif_reg       <= '0;
            for (int i = 0; i < 2; i++)
            begin
                last_e_reg[i] <= '0;
                fa_st_reg[i]  <= '0;
                cmd_reg[i]    <= '0;
                step_reg[i]   <= '0;
                for (int k = 0; k < 3; k++)
                    tel_reg[i][k] <= '0;
            end
        end
        else
        begin
            div_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ex_reg    <= error_x;
                        ey_reg    <= error_y;
                        el_reg    <= elapsed_ms;
                        upd_reg   <= update_state;
                        close_reg <= close_to_target;
                        ax_reg    <= 1'b0;
                        state_reg <= S_AX_BEGIN;
                    end
                end
                S_AX_BEGIN:
                begin
                    if (el_reg < HALF_MS)
                    begin
                        if (upd_reg)
                            last_e_reg[ax_reg] <= 24'(cur_e);
                        for (int k = 0; k < 3; k++)
                            tel_reg[ax_reg][k] <= '0;
                        step_reg[ax_reg] <= '0;
                        state_reg        <= S_NEXT;
                    end
                    else if (!upd_reg)
                        state_reg <= S_ST1;
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= {de[33:0], 16'd0};
                        div_dsr_reg   <= DSR_W'(ut);
                        state_reg     <= S_RATE_W;
                    end
                end
                S_RATE_W:
                begin
                    if (div_done)
                    begin
                        rate_reg  <= clampw(div_q, -RATE_LIM, RATE_LIM);
                        state_reg <= S_NE_M;
                    end
                end
                S_NE_M:
                    state_reg <= S_NE_D;
                S_NE_D:
                begin
                    div_start_reg <= 1'b1;
                    div_dvd_reg   <= {mul_p[41:0], 8'd0};
                    div_dsr_reg   <= DSR_W'(nz);
                    state_reg     <= S_NE_W;
                end
                S_NE_W:
                begin
                    if (div_done)
                    begin
                        ne_reg        <= clampw(div_q, -LIM3, LIM3);
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= {ae[33:0], 16'd0};
                        div_dsr_reg   <= DSR_W'(nz);
                        state_reg     <= S_NM_W;
                    end
                end
                S_NM_W:
                begin
                    if (div_done)
                    begin
                        nm_reg    <= clampw(div_q, '0, LIM3);
                        state_reg <= S_NR1;
                    end
                end
                S_NR1:
                    state_reg <= S_NR2;
                S_NR2:
                begin
                    near_reg  <= (q5 > ONE) ? ONE : q5;
                    avail_reg <= clampw(nm_reg - av1, '0, LIM3);
                    state_reg <= S_SM1;
                end
                S_SM1:
                    state_reg <= S_SM2;
                S_SM2:
                    state_reg <= S_SM3;
                S_SM3:
                begin
                    smooth_reg <= clampw(tp, '0, ONE);
                    state_reg  <= S_FA1;
                end
                S_FA1:
                    state_reg <= S_FA2;
                S_FA2:
                begin
                    fa_reg    <= fa_adj;
                    req_reg   <= clampw(fa_adj + ne_reg, -LIM3, LIM3);
                    state_reg <= S_PR1;
                end
                S_PR1:
                    state_reg <= S_PR2;
                S_PR2:
                begin
                    prop_reg  <= tp;
                    brake_reg <= '0;
                    if (brk_cond)
                    begin
                        div_start_reg <= 1'b1;
                        div_dvd_reg   <= {ae[33:0], 16'd0};
                        div_dsr_reg   <= DSR_W'(pm);
                        state_reg     <= S_FRAC_W;
                    end
                    else
                        state_reg <= S_OVS;
                end
                S_FRAC_W:
                begin
                    if (div_done)
                    begin
                        frac_reg  <= ONE - div_q;
                        state_reg <= S_ADQ1;
                    end
                end
                S_ADQ1:
                    state_reg <= S_ADQ2;
                S_ADQ2:
                begin
                    adq_reg   <= q5;
                    state_reg <= S_AMT1;
                end
                S_AMT1:
                    state_reg <= S_AMT2;
                S_AMT2:
                begin
                    mult_reg  <= clampw(ONE - tp, '0, ONE);
                    state_reg <= S_BRK1;
                end
                S_BRK1:
                    state_reg <= S_BRK2;
                S_BRK2:
                begin
                    dif_reg   <= tp - req_reg;
                    req_reg   <= tp;
                    state_reg <= S_BRK3;
                end
                S_BRK3:
                    state_reg <= S_BRK4;
                S_BRK4:
                begin
                    brake_reg <= tp;
                    state_reg <= S_OVS;
                end
                S_OVS:
                begin
                    cmd_reg[ax_reg]    <= 20'(cmd_new);
                    fa_st_reg[ax_reg]  <= 20'(clampw(fa_o, -LIM3, LIM3));
                    last_e_reg[ax_reg] <= 24'(cur_e);
                    tel_reg[ax_reg][0] <= 24'(clampw(prop_reg, TEL_MIN, TEL_MAX));
                    dif_reg            <= applied - delta;
                    state_reg          <= S_T1;
                end
                S_T1:
                    state_reg <= S_T2;
                S_T2:
                begin
                    tel_reg[ax_reg][1] <= 24'(clampw(tp + brake_reg, TEL_MIN, TEL_MAX));
                    state_reg          <= S_T3;
                end
                S_T3:
                    state_reg <= S_T4;
                S_T4:
                begin
                    tel_reg[ax_reg][2] <= 24'(clampw(tp, TEL_MIN, TEL_MAX));
                    state_reg          <= S_ST1;
                end
                S_ST1:
                    state_reg <= S_ST2;
                S_ST2:
                begin
                    step_reg[ax_reg] <= 16'(clampw(tp, -OUT_LIM, OUT_LIM));
                    state_reg        <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (!ax_reg)
                    begin
                        ax_reg    <= 1'b1;
                        state_reg <= S_AX_BEGIN;
                    end
                    else if (close_reg)
                        state_reg <= S_CLX1;
                    else
                        state_reg <= S_DONE;
                end
                S_CLX1:
                    state_reg <= S_CLX2;
                S_CLX2:
                begin
                    step_reg[0] <= 16'(cl_q);
                    state_reg   <= S_CLY1;
                end
                S_CLY1:
                    state_reg <= S_CLY2;
                S_CLY2:
                begin
                    step_reg[1] <= 16'(cl_q);
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready        = state_reg == S_IDLE;
    assign out_valid       = state_reg == S_DONE;
    assign step_x          = step_reg[0];
    assign step_y          = step_reg[1];
    assign x_proportional  = tel_reg[0][0];
    assign x_slew_residual = tel_reg[0][1];
    assign x_filtered_term = tel_reg[0][2];
    assign y_proportional  = tel_reg[1][0];
    assign y_slew_residual = tel_reg[1][1];
    assign y_filtered_term = tel_reg[1][2];

endmodule

// ===== rtl/two_axis_slew_limited_controller.sv =====
// Two-axis slew-limited controller: configuration registers around the sequenced core.
// Each item is sequenced axis by axis; with update_state set each axis makes three or four
// divisions on the shared divider (none when the frame is short or update_state is clear),
// and divisions by five run on the shared multiplier.
// Throughput: one item at a time; the next transfer is taken once the result is taken.
// Reset: asynchronous, clears controller state and telemetry and loads register defaults.
// Depends on srlc_pkg and srlc_core.
module two_axis_slew_limited_controller
    import srlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [23:0]   error_x,
    input  logic signed [23:0]   error_y,
    input  logic [15:0]          elapsed_ms,
    input  logic                 update_state,
    input  logic                 close_to_target,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   step_x,
    output logic signed [15:0]   step_y,
    output logic signed [23:0]   x_proportional,
    output logic signed [23:0]   x_slew_residual,
    output logic signed [23:0]   x_filtered_term,
    output logic signed [23:0]   y_proportional,
    output logic signed [23:0]   y_slew_residual,
    output logic signed [23:0]   y_filtered_term
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_interval <= 16'd256;
            cfg_reg.norm_scale      <= 16'd256;
            cfg_reg.gain            <= 16'd256;
            cfg_reg.smoothing       <= 16'd0;
            cfg_reg.damping         <= 16'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_UPDATE_INTERVAL: cfg_reg.update_interval <= cfg_data;
                REG_NORM_SCALE:      cfg_reg.norm_scale      <= cfg_data;
                REG_OUTPUT_GAIN:     cfg_reg.gain            <= cfg_data;
                REG_SMOOTHING:       cfg_reg.smoothing       <= cfg_data;
                REG_DAMPING:         cfg_reg.damping         <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    srlc_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .error_x         (error_x),
        .error_y         (error_y),
        .elapsed_ms      (elapsed_ms),
        .update_state    (update_state),
        .close_to_target (close_to_target),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .step_x          (step_x),
        .step_y          (step_y),
        .x_proportional  (x_proportional),
        .x_slew_residual (x_slew_residual),
        .x_filtered_term (x_filtered_term),
        .y_proportional  (y_proportional),
        .y_slew_residual (y_slew_residual),
        .y_filtered_term (y_filtered_term)
    );

endmodule

// ===== tb/sv/two_axis_slew_limited_controller_chk.sv =====
// Checker for the two-axis slew-limited controller: watches the config, input and result
// channels, predicts every result in fixed point and compares it field by field.
// Depends on srlc_pkg for the register index codes.
module two_axis_slew_limited_controller_chk
    import srlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic signed [23:0]   error_x,
    input  logic signed [23:0]   error_y,
    input  logic [15:0]          elapsed_ms,
    input  logic                 update_state,
    input  logic                 close_to_target,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic signed [15:0]   step_x,
    input  logic signed [15:0]   step_y,
    input  logic signed [23:0]   x_proportional,
    input  logic signed [23:0]   x_slew_residual,
    input  logic signed [23:0]   x_filtered_term,
    input  logic signed [23:0]   y_proportional,
    input  logic signed [23:0]   y_slew_residual,
    input  logic signed [23:0]   y_filtered_term,
    output int                   fail_count,
    output int                   steps_pending
);

    localparam longint Q_ONE   = 65536;
    localparam longint CMD_LIM = 196608;
    localparam longint SLEW    = 157286;
    localparam longint STEP_LIM = 25600;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [23:0] tel [6];
    } steps_t;

    steps_t steps_q [$];

    longint interval_r, norm_r, gain_r, smooth_r, damp_r;
    longint prev_err [2];
    longint approach [2];
    longint command [2];
    longint tel_hold [6];

    function automatic longint lim(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint axis_step(input int a, input longint e, input longint el,
                                         input bit upd);
        longint prev, ut, nz, rate, ne, dir, ae, nm, near, avail, sm, fa, req, prop;
        longint brake, pm, frac, amt, mult, req0, delta, applied;
        if (el < 128) begin
            if (upd)
                prev_err[a] = e;
            tel_hold[a*3] = 0;
            tel_hold[a*3+1] = 0;
            tel_hold[a*3+2] = 0;
            return 0;
        end
        if (upd) begin
            prev = prev_err[a];
            ut = interval_r < 256 ? 256 : interval_r;
            nz = norm_r < 256 ? 256 : norm_r;
            rate = lim((e - prev) * Q_ONE / ut, -10 * Q_ONE, 10 * Q_ONE);
            ne = lim(e * gain_r * 256 / nz, -CMD_LIM, CMD_LIM);
            dir = e < 0 ? -1 : 1;
            ae = mag(e);
            nm = lim(ae * Q_ONE / nz, 0, CMD_LIM);
            near = ae * 256 / 20;
            if (near > Q_ONE)
                near = Q_ONE;
            avail = -rate * dir;
            if (avail < 0)
                avail = 0;
            avail = lim(nm - avail, 0, CMD_LIM);
            sm = lim(nz * smooth_r * near / Q_ONE, 0, Q_ONE);
            fa = approach[a];
            fa += (avail * dir - fa) * sm / Q_ONE;
            if ((fa < 0 && e > 0) || (fa > 0 && e < 0))
                fa = fa * 3 / 4;
            req = lim(fa + ne, -CMD_LIM, CMD_LIM);
            prop = ne * nz / Q_ONE;
            brake = 0;
            pm = mag(prev);
            if (pm > 256 && pm > ae && ((prev > 0 && e > 0) || (prev < 0 && e < 0))) begin
                frac = Q_ONE - ae * Q_ONE / pm;
                amt = frac * (damp_r * 256 / 5) / Q_ONE;
                mult = lim(Q_ONE - amt, 0, Q_ONE);
                req0 = req;
                req = req * mult / Q_ONE;
                brake = (req - req0) * nz / Q_ONE;
            end
            if ((req < 0 && e > 0) || (req > 0 && e < 0)) begin
                req = req * 3 / 4;
                fa = fa * 3 / 4;
            end
            delta = req - command[a];
            applied = lim(delta, -SLEW, SLEW);
            command[a] = lim(command[a] + applied, -CMD_LIM, CMD_LIM);
            approach[a] = lim(fa, -CMD_LIM, CMD_LIM);
            prev_err[a] = e;
            tel_hold[a*3] = lim(prop, -8388608, 8388607);
            tel_hold[a*3+1] = lim((applied - delta) * nz / Q_ONE + brake, -8388608, 8388607);
            tel_hold[a*3+2] = lim(approach[a] * nz / Q_ONE, -8388608, 8388607);
        end
        return lim(el * command[a] / Q_ONE, -STEP_LIM, STEP_LIM);
    endfunction

    task automatic predict_steps();
        steps_t s;
        longint sx, sy;
        sx = axis_step(0, longint'(error_x), longint'(elapsed_ms), update_state);
        sy = axis_step(1, longint'(error_y), longint'(elapsed_ms), update_state);
        if (close_to_target) begin
            sx = sx * 3 / 5;
            sy = sy * 3 / 5;
        end
        s.sx = sx[15:0];
        s.sy = sy[15:0];
        for (int i = 0; i < 6; i++)
            s.tel[i] = tel_hold[i][23:0];
        steps_q.push_back(s);
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_steps();
        steps_t s;
        if (steps_q.size() == 0) begin
            $error("result transfer with no expected result");
            fail_count++;
            return;
        end
        s = steps_q.pop_front();
        check_field("step_x", s.sx, step_x);
        check_field("step_y", s.sy, step_y);
        check_field("x_proportional", s.tel[0], x_proportional);
        check_field("x_slew_residual", s.tel[1], x_slew_residual);
        check_field("x_filtered_term", s.tel[2], x_filtered_term);
        check_field("y_proportional", s.tel[3], y_proportional);
        check_field("y_slew_residual", s.tel[4], y_slew_residual);
        check_field("y_filtered_term", s.tel[5], y_filtered_term);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_r = 256;
            norm_r = 256;
            gain_r = 256;
            smooth_r = 0;
            damp_r = 0;
            for (int i = 0; i < 2; i++)
            begin
                prev_err[i] = 0;
                approach[i] = 0;
                command[i] = 0;
            end
            for (int i = 0; i < 6; i++)
                tel_hold[i] = 0;
            steps_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_steps();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_UPDATE_INTERVAL: interval_r = cfg_data;
                    REG_NORM_SCALE:      norm_r = cfg_data;
                    REG_OUTPUT_GAIN:     gain_r = cfg_data;
                    REG_SMOOTHING:       smooth_r = cfg_data;
                    REG_DAMPING:         damp_r = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_steps();
        end
        steps_pending = steps_q.size();
    end

endmodule

// ===== tb/sv/two_axis_slew_limited_controller_tb.sv =====
// Top of the two-axis slew-limited controller testbench: clock, reset, stimulus and verdict.
// Depends on srlc_pkg, the controller RTL and two_axis_slew_limited_controller_chk.
module two_axis_slew_limited_controller_tb;
    import srlc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [23:0]   error_x = '0;
    logic signed [23:0]   error_y = '0;
    logic [15:0]          elapsed_ms = '0;
    logic                 update_state = 1'b0;
    logic                 close_to_target = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [15:0]   step_x, step_y;
    logic signed [23:0]   x_proportional, x_slew_residual, x_filtered_term;
    logic signed [23:0]   y_proportional, y_slew_residual, y_filtered_term;
    int                   fail_count, steps_pending;
    bit                   quiet = 0;
    int                   stall_left = 0;
    int                   cycles = 0;
    logic signed [23:0]   track [2];

    two_axis_slew_limited_controller dut (.*);
    two_axis_slew_limited_controller_chk chk (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 5)) @(posedge clk);
    endtask

    task automatic send_item(input logic [23:0] ex, input logic [23:0] ey,
                             input logic [15:0] el, input bit upd, input bit cl);
        idle_burst();
        @(posedge clk);
        in_valid <= 1'b1;
        error_x <= ex;
        error_y <= ey;
        elapsed_ms <= el;
        update_state <= upd;
        close_to_target <= cl;
        do @(posedge clk); while (!in_ready);
        in_valid <= 1'b0;
    endtask

    task automatic drain_steps();
        while (steps_pending != 0 || in_valid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(input logic [15:0] ui, input logic [15:0] ns,
                             input logic [15:0] g, input logic [15:0] sm,
                             input logic [15:0] dp);
        drain_steps();
        write_reg(REG_UPDATE_INTERVAL, ui);
        write_reg(REG_NORM_SCALE, ns);
        write_reg(REG_OUTPUT_GAIN, g);
        write_reg(REG_SMOOTHING, sm);
        write_reg(REG_DAMPING, dp);
    endtask

    function automatic logic [23:0] pick_error(input int a);
        int mode;
        logic signed [23:0] v;
        mode = $urandom_range(0, 11);
        case (mode)
            0: v = 24'(int'($urandom_range(0, 6000)) - 3000);
            1: v = 24'(int'($urandom_range(0, 200000)) - 100000);
            2: v = 24'($urandom());
            3: v = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            4: v = '0;
            5: v = -track[a];
            default: v = 24'(int'(track[a]) - int'(track[a]) / int'($urandom_range(2, 8))
                             + int'($urandom_range(0, 20)) - 10);
        endcase
        if ($urandom_range(0, 15) == 0)
            v = 24'(int'($urandom_range(0, 4000)) - 2000);
        track[a] = v;
        return v;
    endfunction

    task automatic random_items(input int n);
        logic [15:0] el;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: el = 16'($urandom_range(0, 127));
                1: el = 16'($urandom());
                2: el = $urandom_range(0, 1) ? 16'hffff : 16'd128;
                default: el = 16'($urandom_range(128, 8192));
            endcase
            send_item(pick_error(0), pick_error(1), el, $urandom_range(0, 7) != 0,
                      $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        track[0] = 24'sd5000;
        track[1] = -24'sd5000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(24'sh7fffff, 24'sh800000, 16'hffff, 1'b1, 1'b0);
        send_item(24'sh800000, 24'sh7fffff, 16'hffff, 1'b1, 1'b1);
        send_item(24'sd0, 24'sd0, 16'd256, 1'b1, 1'b0);
        send_item(24'sd1000, -24'sd1000, 16'd0, 1'b1, 1'b0);
        send_item(24'sd1000, -24'sd1000, 16'd127, 1'b1, 1'b1);
        send_item(24'sd1000, -24'sd1000, 16'd128, 1'b1, 1'b0);
        send_item(24'sd2000, 24'sd3, 16'd4096, 1'b0, 1'b1);
        load_regs(16'd512, 16'd300, 16'd700, 16'd200, 16'd100);
        send_item(24'sd4000, -24'sd4000, 16'd1024, 1'b1, 1'b0);
        send_item(24'sd3000, -24'sd3000, 16'd1024, 1'b1, 1'b0);
        send_item(24'sd1500, -24'sd1500, 16'd1024, 1'b1, 1'b1);
        send_item(-24'sd1200, 24'sd1200, 16'd1024, 1'b1, 1'b0);
        send_item(-24'sd1, 24'sd1, 16'd1024, 1'b1, 1'b0);
        send_item(24'sd0, 24'sd0, 16'd1024, 1'b1, 1'b0);
        send_item(24'sd50, -24'sd50, 16'd1024, 1'b0, 1'b0);
        send_item(24'sd9000, 24'sd9000, 16'd100, 1'b1, 1'b0);
        drain_steps();
        write_reg(3'd7, 16'hffff);
        write_reg(3'd5, 16'h1234);
        send_item(24'sd800, 24'sd800, 16'd2048, 1'b1, 1'b0);

        random_items(150);
        load_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        random_items(120);
        load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_items(120);
        load_regs(16'd256, 16'd256, 16'd256, 16'd0, 16'd0);
        random_items(120);
        for (int p = 0; p < 4; p++)
        begin
            load_regs(16'($urandom()), 16'($urandom_range(0, 2000)),
                      16'($urandom_range(0, 4000)), 16'($urandom_range(0, 600)),
                      16'($urandom_range(0, 3000)));
            random_items(100);
        end
        quiet = 1;
        load_regs(16'd300, 16'd256, 16'd1000, 16'd300, 16'd500);
        random_items(100);

        drain_steps();
        repeat (800) @(posedge clk);
        if (fail_count == 0 && steps_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
